// File: rtl/sdct_pkg.sv
`timescale 1ns / 1ps

package sdct_pkg;

  // Fixed field widths
  localparam int unsigned SdayW  = 22;
  localparam int unsigned FracW  = 32;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  // Calendar and clock constants
  localparam int unsigned SecScale    = 675;      // 86400 = 675 * 2^7
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DayShift    = 719468 - 25569;
  localparam int unsigned DaysPerEra  = 146097;
  localparam int unsigned YearsPerEra = 400;
  localparam int unsigned DaysPerYear = 365;

  // Internal widths
  localparam int unsigned SecsW = 17;   // seconds of day, up to 86400
  localparam int unsigned ZW    = 23;   // day count from the March era base
  localparam int unsigned EraW  = 6;
  localparam int unsigned DoeW  = 18;
  localparam int unsigned RemW  = 12;   // seconds within the hour
  localparam int unsigned YoeW  = 9;
  localparam int unsigned DoyW  = 9;
  localparam int unsigned MpW   = 4;

  // Reciprocals for exact division by constants: q = (x * M) >> S,
  // with M = ceil(2^S / d) and 2^S > 2^width(x) * d.
  localparam int unsigned EraS  = 42;
  localparam logic [24:0] EraM  = 25'(((64'd1 << EraS) + 64'd146097 - 64'd1) / 64'd146097);
  localparam int unsigned HourS = 30;
  localparam logic [18:0] HourM = 19'(((64'd1 << HourS) + 64'd3600 - 64'd1) / 64'd3600);
  localparam int unsigned MinS  = 19;
  localparam logic [13:0] MinM  = 14'(((64'd1 << MinS) + 64'd60 - 64'd1) / 64'd60);
  localparam int unsigned Q4yS  = 30;
  localparam logic [19:0] Q4yM  = 20'(((64'd1 << Q4yS) + 64'd1460 - 64'd1) / 64'd1460);
  localparam int unsigned QCenS = 35;
  localparam logic [19:0] QCenM = 20'(((64'd1 << QCenS) + 64'd36524 - 64'd1) / 64'd36524);
  localparam int unsigned YoeS  = 28;
  localparam logic [19:0] YoeM  = 20'(((64'd1 << YoeS) + 64'd365 - 64'd1) / 64'd365);
  localparam int unsigned Y100S = 17;
  localparam logic [10:0] Y100M = 11'(((64'd1 << Y100S) + 64'd100 - 64'd1) / 64'd100);
  localparam int unsigned MpS   = 20;
  localparam logic [12:0] MpM   = 13'(((64'd1 << MpS) + 64'd153 - 64'd1) / 64'd153);

  localparam int unsigned Latency = 11;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } tod_t;

  // Day of the March-based year on which month index mp starts: (153*mp+2)/5
  function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
    logic [DoyW-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/serial_date_to_civil_time_unit.sv
`timescale 1ns / 1ps

// Serial date to civil date and time converter.
// Request channel: drive serial_day_i and day_fraction_i and raise start for
// one cycle per request. busy is always low, so a request is taken on every
// cycle that start is high, back to back without gaps.
// Result channel: done_o pulses for exactly one cycle with year_o, month_o,
// day_of_month_o, hour_o, minute_o and second_o valid in that cycle. There
// is no back pressure; the receiver must take the result when it appears.
// Throughput: one request per cycle, through an eleven-stage pipeline.
// Results come out in request order, one per request.
// Reset clears the stage valid bits only; no result is emitted for requests
// in flight at reset. The pipeline holds no state between requests.
module serial_date_to_civil_time_unit
  import sdct_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [SdayW-1:0]      serial_day_i,
  input  logic [FracW-1:0]      day_fraction_i,
  output logic                  done_o,
  output logic [YearW-1:0]      year_o,
  output logic [MonW-1:0]       month_o,
  output logic [DomW-1:0]       day_of_month_o,
  output logic [HourW-1:0]      hour_o,
  output logic [MinW-1:0]       minute_o,
  output logic [SecW-1:0]       second_o
);

  localparam int unsigned ProdW = FRACTION_BITS + 10;
  localparam logic [ProdW-1:0] Rnd = ProdW'(1) << (FRACTION_BITS - 8);

  logic [FRACTION_BITS-1:0] frac;
  logic [Latency-1:0]       vld_q;

  // Stage registers
  logic [SecsW-1:0] s1_secs_q;
  logic [SdayW-1:0] s1_sday_q;
  logic [SecsW-1:0] s2_secs_q;
  logic [ZW-1:0]    s2_z_q;
  logic [SecsW-1:0] s3_secs_q;
  logic [ZW-1:0]    s3_z_q;
  logic [EraW-1:0]  s3_era_q;
  logic [HourW-1:0] s3_hour_q;
  logic [DoeW-1:0]  s4_doe_q;
  logic [RemW-1:0]  s4_rem_q;
  logic [EraW-1:0]  s4_era_q;
  logic [HourW-1:0] s4_hour_q;
  logic [DoeW-1:0]  s5_doe_q;
  logic [6:0]       s5_q4y_q;
  logic [2:0]       s5_qcen_q;
  logic             s5_full_q;
  logic [RemW-1:0]  s5_rem_q;
  logic [MinW-1:0]  s5_min_q;
  logic [EraW-1:0]  s5_era_q;
  logic [HourW-1:0] s5_hour_q;
  logic [DoeW-1:0]  s6_doe_q;
  logic [DoeW-1:0]  s6_num_q;
  logic [EraW-1:0]  s6_era_q;
  tod_t             s6_tod_q;
  logic [DoeW-1:0]  s7_doe_q;
  logic [YoeW-1:0]  s7_yoe_q;
  logic [EraW-1:0]  s7_era_q;
  tod_t             s7_tod_q;
  logic [DoeW-1:0]  s8_doe_q;
  logic [DoeW-1:0]  s8_y365_q;
  logic [1:0]       s8_q100_q;
  logic [YoeW-1:0]  s8_yoe_q;
  logic [EraW-1:0]  s8_era_q;
  tod_t             s8_tod_q;
  logic [DoyW-1:0]  s9_doy_q;
  logic [YoeW-1:0]  s9_yoe_q;
  logic [EraW-1:0]  s9_era_q;
  tod_t             s9_tod_q;
  logic [MpW-1:0]   s10_mp_q;
  logic [DoyW-1:0]  s10_doy_q;
  logic [YearW-1:0] s10_ybase_q;
  tod_t             s10_tod_q;
  logic [YearW-1:0] s11_year_q;
  logic [MonW-1:0]  s11_mon_q;
  logic [DomW-1:0]  s11_dom_q;
  tod_t             s11_tod_q;

  // Next values
  logic [ProdW-1:0] sec_prod;
  logic [SecsW-1:0] s1_secs_d;
  logic             carry;
  logic [SecsW-1:0] s2_secs_d;
  logic [ZW-1:0]    s2_z_d;
  logic [47:0]      era_prod;
  logic [35:0]      hour_prod;
  logic [DoeW-1:0]  s4_doe_d;
  logic [RemW-1:0]  s4_rem_d;
  logic [37:0]      q4y_prod;
  logic [37:0]      qcen_prod;
  logic [25:0]      min_prod;
  logic [DoeW-1:0]  s6_num_d;
  logic [SecW-1:0]  s6_sec_d;
  logic [37:0]      yoe_prod;
  logic [DoeW-1:0]  s8_y365_d;
  logic [19:0]      y100_prod;
  logic [DoeW-1:0]  doy_base;
  logic [DoyW-1:0]  s9_doy_d;
  logic [10:0]      mp_x;
  logic [23:0]      mp_prod;
  logic [YearW-1:0] s10_ybase_d;
  logic [DoyW-1:0]  mstart;
  logic [DomW-1:0]  s11_dom_d;
  logic [MonW-1:0]  s11_mon_d;
  logic [YearW-1:0] s11_year_d;

  assign busy = 1'b0;

  generate
    if (FRACTION_BITS <= FracW) begin : g_frac_trunc
      assign frac = day_fraction_i[FRACTION_BITS-1:0];
    end else begin : g_frac_ext
      assign frac = {{(FRACTION_BITS - FracW){1'b0}}, day_fraction_i};
    end
  endgenerate

  always_comb begin
    // Stage 1: fraction to rounded seconds
    sec_prod  = ProdW'(frac) * ProdW'(SecScale) + Rnd;
    s1_secs_d = sec_prod[ProdW-1:FRACTION_BITS-7];

    // Stage 2: fold a rounding carry into the day count
    carry     = (s1_secs_q >= SecsW'(SecsPerDay));
    s2_secs_d = carry ? (s1_secs_q - SecsW'(SecsPerDay)) : s1_secs_q;
    s2_z_d    = ZW'(s1_sday_q) + ZW'(carry) + ZW'(DayShift);

    // Stage 3: era and hour quotients
    era_prod  = 48'(s2_z_q) * 48'(EraM);
    hour_prod = 36'(s2_secs_q) * 36'(HourM);

    // Stage 4: remainders
    s4_doe_d = DoeW'(s3_z_q - ZW'(s3_era_q) * ZW'(DaysPerEra));
    s4_rem_d = RemW'(s3_secs_q - SecsW'(s3_hour_q) * SecsW'(SecsPerHour));

    // Stage 5: leap corrections and minute quotient
    q4y_prod  = 38'(s4_doe_q) * 38'(Q4yM);
    qcen_prod = 38'(s4_doe_q) * 38'(QCenM);
    min_prod  = 26'(s4_rem_q) * 26'(MinM);

    // Stage 6: day of era with leap days removed, seconds
    s6_num_d = s5_doe_q - DoeW'(s5_q4y_q) + DoeW'(s5_qcen_q) - DoeW'(s5_full_q);
    s6_sec_d = SecW'(s5_rem_q - RemW'(s5_min_q) * RemW'(SecsPerMin));

    // Stage 7: year of era
    yoe_prod = 38'(s6_num_q) * 38'(YoeM);

    // Stage 8: days in the elapsed years of the era
    s8_y365_d = DoeW'(s7_yoe_q) * DoeW'(DaysPerYear);
    y100_prod = 20'(s7_yoe_q) * 20'(Y100M);

    // Stage 9: day of the March-based year
    doy_base = s8_y365_q + DoeW'(s8_yoe_q[YoeW-1:2]) - DoeW'(s8_q100_q);
    s9_doy_d = DoyW'(s8_doe_q - doy_base);

    // Stage 10: month index and year base
    mp_x        = {s9_doy_q, 2'b00} + 11'(s9_doy_q) + 11'd2;
    mp_prod     = 24'(mp_x) * 24'(MpM);
    s10_ybase_d = YearW'(s9_yoe_q) + YearW'(s9_era_q) * YearW'(YearsPerEra);

    // Stage 11: civil month, day and year
    mstart     = month_start(s10_mp_q);
    s11_dom_d  = DomW'(s10_doy_q - mstart + 9'd1);
    s11_mon_d  = (s10_mp_q < 4'd10) ? (s10_mp_q + 4'd3) : (s10_mp_q - 4'd9);
    s11_year_d = s10_ybase_q + YearW'(s11_mon_d <= 4'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_secs_q <= s1_secs_d;
    s1_sday_q <= serial_day_i;

    s2_secs_q <= s2_secs_d;
    s2_z_q    <= s2_z_d;

    s3_secs_q <= s2_secs_q;
    s3_z_q    <= s2_z_q;
    s3_era_q  <= era_prod[47:42];
    s3_hour_q <= hour_prod[34:30];

    s4_doe_q  <= s4_doe_d;
    s4_rem_q  <= s4_rem_d;
    s4_era_q  <= s3_era_q;
    s4_hour_q <= s3_hour_q;

    s5_doe_q  <= s4_doe_q;
    s5_q4y_q  <= q4y_prod[36:30];
    s5_qcen_q <= qcen_prod[37:35];
    s5_full_q <= (s4_doe_q == DoeW'(DaysPerEra - 1));
    s5_rem_q  <= s4_rem_q;
    s5_min_q  <= min_prod[24:19];
    s5_era_q  <= s4_era_q;
    s5_hour_q <= s4_hour_q;

    s6_doe_q        <= s5_doe_q;
    s6_num_q        <= s6_num_d;
    s6_era_q        <= s5_era_q;
    s6_tod_q.hour   <= s5_hour_q;
    s6_tod_q.minute <= s5_min_q;
    s6_tod_q.second <= s6_sec_d;

    s7_doe_q <= s6_doe_q;
    s7_yoe_q <= yoe_prod[36:28];
    s7_era_q <= s6_era_q;
    s7_tod_q <= s6_tod_q;

    s8_doe_q  <= s7_doe_q;
    s8_y365_q <= s8_y365_d;
    s8_q100_q <= y100_prod[18:17];
    s8_yoe_q  <= s7_yoe_q;
    s8_era_q  <= s7_era_q;
    s8_tod_q  <= s7_tod_q;

    s9_doy_q <= s9_doy_d;
    s9_yoe_q <= s8_yoe_q;
    s9_era_q <= s8_era_q;
    s9_tod_q <= s8_tod_q;

    s10_mp_q    <= mp_prod[23:20];
    s10_doy_q   <= s9_doy_q;
    s10_ybase_q <= s10_ybase_d;
    s10_tod_q   <= s9_tod_q;

    s11_year_q <= s11_year_d;
    s11_mon_q  <= s11_mon_d;
    s11_dom_q  <= s11_dom_d;
    s11_tod_q  <= s10_tod_q;
  end

  assign done_o         = vld_q[Latency-1];
  assign year_o         = s11_year_q;
  assign month_o        = s11_mon_q;
  assign day_of_month_o = s11_dom_q;
  assign hour_o         = s11_tod_q.hour;
  assign minute_o       = s11_tod_q.minute;
  assign second_o       = s11_tod_q.second;

  a_era_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (s4_doe_q < DoeW'(DaysPerEra)) && (s4_rem_q < RemW'(SecsPerHour)))
    else $error("era or hour remainder out of range");

  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> s9_doy_q <= DoyW'(DaysPerYear))
    else $error("day of year out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (day_of_month_o >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("time of day out of range");

endmodule

// File: bench/tb_serial_date_to_civil_time_unit.sv
`timescale 1ns / 1ps

module tb_serial_date_to_civil_time_unit;
  import sdct_pkg::*;

  localparam int unsigned FracBits    = 32;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned RandomItems = 1300;
  localparam logic [SdayW-1:0] LastSerial  = 22'd2958465;
  // largest fraction that still rounds below a full day
  localparam logic [FracW-1:0] LastNoCarry = 32'hFFFF9EE8;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DomW-1:0]  dom;
    tod_t             tod;
  } civil_t;

  class civil_time_board #(int unsigned FB = 32);
    civil_t      dates_due[$];
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_far;

    function new();
      mismatches = 0;
      n_checked  = 0;
      n_far      = 0;
    endfunction

    function civil_t to_civil(logic [SdayW-1:0] sday, logic [FracW-1:0] frac_in);
      longint unsigned day, frac, secs, z, era, doe, yoe, doy, mp, dd, mm, yy;
      civil_t r;
      day  = sday;
      frac = frac_in;
      frac = frac & ((64'd1 << FB) - 64'd1);
      secs = (frac * SecScale + (64'd1 << (FB - 8))) >> (FB - 7);
      // carry a rounded-up midnight into the next day
      if (secs >= SecsPerDay) begin
        secs = secs - SecsPerDay;
        day  = day + 1;
      end
      z   = day + DayShift;
      era = z / DaysPerEra;
      doe = z - era * DaysPerEra;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / DaysPerYear;
      doy = doe - (DaysPerYear * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      dd  = doy - (153 * mp + 2) / 5 + 1;
      mm  = (mp < 10) ? mp + 3 : mp - 9;
      yy  = yoe + era * YearsPerEra + ((mm <= 2) ? 1 : 0);
      r.year       = YearW'(yy);
      r.month      = MonW'(mm);
      r.dom        = DomW'(dd);
      r.tod.hour   = HourW'(secs / SecsPerHour);
      r.tod.minute = MinW'((secs % SecsPerHour) / SecsPerMin);
      r.tod.second = SecW'(secs % SecsPerMin);
      return r;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_request(logic [SdayW-1:0] sday, logic [FracW-1:0] frac);
      dates_due.push_back(to_civil(sday, frac));
    endfunction

    function int unsigned pending();
      return dates_due.size();
    endfunction

    task check_result(civil_t got);
      civil_t want;
      if (dates_due.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d with no request outstanding",
                                  got.year, got.month, got.dom));
        return;
      end
      want = dates_due.pop_front();
      n_checked++;
      if (want.year > 9999) n_far++;
      if (got.year !== want.year)
        report_mismatch($sformatf("result %0d year %0d, want %0d",
                                  n_checked, got.year, want.year));
      if (got.month !== want.month)
        report_mismatch($sformatf("result %0d month %0d, want %0d",
                                  n_checked, got.month, want.month));
      if (got.dom !== want.dom)
        report_mismatch($sformatf("result %0d day %0d, want %0d",
                                  n_checked, got.dom, want.dom));
      if (got.tod.hour !== want.tod.hour)
        report_mismatch($sformatf("result %0d hour %0d, want %0d",
                                  n_checked, got.tod.hour, want.tod.hour));
      if (got.tod.minute !== want.tod.minute)
        report_mismatch($sformatf("result %0d minute %0d, want %0d",
                                  n_checked, got.tod.minute, want.tod.minute));
      if (got.tod.second !== want.tod.second)
        report_mismatch($sformatf("result %0d second %0d, want %0d",
                                  n_checked, got.tod.second, want.tod.second));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [SdayW-1:0]  serial_day_i;
  logic [FracW-1:0]  day_fraction_i;
  logic              done_o;
  logic [YearW-1:0]  year_o;
  logic [MonW-1:0]   month_o;
  logic [DomW-1:0]   day_of_month_o;
  logic [HourW-1:0]  hour_o;
  logic [MinW-1:0]   minute_o;
  logic [SecW-1:0]   second_o;
  civil_t            seen;

  civil_time_board #(FracBits) sb;
  int unsigned idle_cycles = 0;

  serial_date_to_civil_time_unit #(
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .serial_day_i   (serial_day_i),
    .day_fraction_i (day_fraction_i),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  assign seen = {year_o, month_o, day_of_month_o, hour_o, minute_o, second_o};

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(seen);
    if ((rst_ni && start && busy === 1'b0) || done_o === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no request or result for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  function automatic logic [SdayW-1:0] pick_day();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return SdayW'($urandom_range(0, LastSerial));
    if (r < 85) return SdayW'($urandom_range(LastSerial - 800, LastSerial));
    if (r < 90) return SdayW'($urandom_range(0, 800));
    return SdayW'($urandom);
  endfunction

  function automatic logic [FracW-1:0] pick_fraction();
    int unsigned     r;
    longint unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 86399);
    if (r < 60) return $urandom;
    if (r < 72) return $urandom_range(32'hFFFF0000, 32'hFFFFFFFF);
    // straddle a half-second rounding boundary
    if (r < 90) return FracW'((((2 * k + 1) << 32) / 172800) + $urandom_range(0, 2) - 1);
    return FracW'((k << 32) / 86400);
  endfunction

  task automatic send_request(logic [SdayW-1:0] sday, logic [FracW-1:0] frac,
                              int unsigned gap);
    start          <= 1'b1;
    serial_day_i   <= sday;
    day_fraction_i <= frac;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(sday, frac);
    if (gap != 0) begin
      // drive junk while idle; it must be ignored
      start          <= 1'b0;
      serial_day_i   <= SdayW'($urandom);
      day_fraction_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_request(22'd0, 32'd0, pick_gap(0));
    send_request(22'd0, 32'hFFFFFFFF, pick_gap(0));
    send_request(22'd0, 32'd24855, pick_gap(0));
    send_request(22'd0, 32'd24856, pick_gap(0));
    send_request(22'd2, 32'd1, pick_gap(0));
    send_request(22'd60, 32'd0, pick_gap(0));
    send_request(22'd61, 32'h80000000, pick_gap(0));
    send_request(22'd25569, 32'd0, pick_gap(0));
    send_request(22'd36585, 32'h40000000, pick_gap(0));
    send_request(22'd36586, 32'hC0000000, pick_gap(0));
    send_request(22'd36525, LastNoCarry, pick_gap(0));
    send_request(22'd36525, LastNoCarry + 32'd1, pick_gap(0));
    send_request(LastSerial, 32'd0, pick_gap(0));
    send_request(LastSerial, LastNoCarry, pick_gap(0));
    send_request(LastSerial, 32'hFFFFFFFF, pick_gap(0));
    send_request(22'h3FFFFF, 32'd0, pick_gap(0));
    send_request(22'h3FFFFF, 32'hFFFFFFFF, pick_gap(0));
    send_request(22'h2AAAAA, 32'h55555555, pick_gap(0));
    send_request(22'h155555, 32'hAAAAAAAA, pick_gap(0));
  endtask

  task automatic run_random();
    for (int unsigned i = 0; i < RandomItems; i++) begin
      send_request(pick_day(), pick_fraction(), pick_gap((i % 200) < 40));
      // hold off until the pipeline has drained
      if (i == 450 || i == 950) begin
        start <= 1'b0;
        wait_for_results();
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    serial_day_i   = '0;
    day_fraction_i = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    start <= 1'b0;
    wait_for_results();
    repeat (Latency + 4) @(posedge clk_i);
    $display("checked %0d conversions, %0d of them landing after year 9999",
             sb.n_checked, sb.n_far);
    $display("edge dates, rounding carries, full 22-bit day counts and random gaps");
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sdct_pkg.sv
rtl/serial_date_to_civil_time_unit.sv
bench/tb_serial_date_to_civil_time_unit.sv
